// File: design/cgd_pkg.sv
// Shared constants, types and controller/datapath records for the CTC greedy decoder.
package cgd_pkg;

   localparam int SCORE_W   = 16;
   localparam int IDX_W     = 13;
   localparam int DICT_W    = 14;
   localparam int SUM_W     = 23;
   localparam int COUNT_W   = 7;
   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 2;

   localparam logic [DICT_W-1:0]  DICT_RESET = DICT_W'(8192);
   localparam logic [ADDR_W-1:0]  ADDR_DICT_SIZE = ADDR_W'(0);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic        [IDX_W-1:0]   index_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic        [COUNT_W-1:0] count_type;
   typedef logic        [DICT_W-1:0]  dict_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIV,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic load_summary;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic seq_end;
      logic div_last;
   } ctl_stat_type;

endpackage

// File: design/cgd_if.sv
// Valid/ready channel interfaces for score input and decoded result output.
interface cgd_req_if;
   logic                valid;
   logic                ready;
   cgd_pkg::score_type  class_score;
   logic                end_of_step;
   logic                end_of_sequence;

   modport source (output valid, class_score, end_of_step, end_of_sequence, input ready);
   modport sink   (input valid, class_score, end_of_step, end_of_sequence, output ready);
endinterface

interface cgd_rsp_if;
   logic                valid;
   logic                ready;
   logic                result_kind;
   cgd_pkg::index_type  char_index;
   cgd_pkg::score_type  mean_score;
   cgd_pkg::count_type  char_count;
   logic                last_result;

   modport source (output valid, result_kind, char_index, mean_score, char_count, last_result,
                   input ready);
   modport sink   (input valid, result_kind, char_index, mean_score, char_count, last_result,
                   output ready);
endinterface

// File: design/cgd_ctrl.sv
// Sequencing state machine: input acceptance, mean divider run and summary issue.
module cgd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cgd_pkg::ctl_stat_type stat,
   output cgd_pkg::ctl_cmd_type  cmd
);
   import cgd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_RUN: begin
            req_ready  = stat.out_free;
            cmd.accept = req_valid && stat.out_free;
            if (cmd.accept && stat.seq_end) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (stat.out_free) begin
               cmd.load_summary = 1'b1;
               state_in         = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

endmodule

// File: design/cgd_dp.sv
// Datapath: argmax tracking, kept-character sum and count, serial divider, result register.
module cgd_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  cgd_pkg::score_type    class_score,
   input  logic                  end_of_step,
   input  logic                  end_of_sequence,
   input  cgd_pkg::dict_type     dict_size,
   input  cgd_pkg::ctl_cmd_type  cmd,
   output cgd_pkg::ctl_stat_type stat,
   cgd_rsp_if.source             rsp_chan
);
   import cgd_pkg::*;

   localparam score_type SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam sum_type   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
   localparam sum_type   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

   score_type best_score_ff, best_score_in;
   index_type best_index_ff, best_index_in;
   index_type class_counter_ff, class_counter_in;
   index_type prev_argmax_ff, prev_argmax_in;
   logic      first_step_ff, first_step_in;
   sum_type   score_sum_ff, score_sum_in;
   count_type kept_count_ff, kept_count_in;

   logic [SUM_W-1:0]     dvd_ff, dvd_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   count_type            dsr_ff, dsr_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic      full_ff, full_in;
   logic      kind_ff, kind_in;
   index_type index_ff, index_in;
   score_type mean_ff, mean_in;
   count_type count_ff, count_in;
   logic      last_ff, last_in;

   logic               gt;
   score_type          best_cur;
   index_type          idx_cur;
   logic               kept;
   logic               emit_char;
   logic signed [SUM_W:0] sum_wide;
   sum_type            sum_sat;
   sum_type            sum_upd;
   count_type          count_upd;
   logic [SUM_W-1:0]   sum_mag;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   diff;
   logic               ge;
   logic [SUM_W-1:0]   quot_signed;

   assign gt       = class_score > best_score_ff;
   assign best_cur = gt ? class_score : best_score_ff;
   assign idx_cur  = gt ? class_counter_ff : best_index_ff;
   assign kept     = (idx_cur != '0) && (first_step_ff || (idx_cur != prev_argmax_ff));
   assign emit_char = cmd.accept && end_of_step && kept &&
                      ({1'b0, idx_cur} < dict_size);

   assign sum_wide = {score_sum_ff[SUM_W-1], score_sum_ff} +
                     (SUM_W+1)'(best_cur);

   always_comb begin
      if (sum_wide > (SUM_W+1)'(SUM_MAX)) begin
         sum_sat = SUM_MAX;
      end else if (sum_wide < (SUM_W+1)'(SUM_MIN)) begin
         sum_sat = SUM_MIN;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   assign sum_upd   = kept ? sum_sat : score_sum_ff;
   assign count_upd = (kept && (kept_count_ff != COUNT_MAX)) ? kept_count_ff + 1'b1
                                                             : kept_count_ff;
   assign sum_mag   = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);

   assign trial = {rem_ff, dvd_ff[SUM_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};
   assign quot_signed = neg_ff ? SUM_W'(-dvd_ff) : dvd_ff;

   assign stat.out_free = !full_ff || rsp_chan.ready;
   assign stat.seq_end  = end_of_step && end_of_sequence;
   assign stat.div_last = cnt_ff == DIV_LAST;

   always_comb begin
      best_score_in    = best_score_ff;
      best_index_in    = best_index_ff;
      class_counter_in = class_counter_ff;
      prev_argmax_in   = prev_argmax_ff;
      first_step_in    = first_step_ff;
      score_sum_in     = score_sum_ff;
      kept_count_in    = kept_count_ff;
      if (cmd.accept) begin
         if (end_of_step) begin
            best_score_in    = SCORE_MIN;
            best_index_in    = '0;
            class_counter_in = '0;
            if (end_of_sequence) begin
               prev_argmax_in = '0;
               first_step_in  = 1'b1;
               score_sum_in   = '0;
               kept_count_in  = '0;
            end else begin
               prev_argmax_in = idx_cur;
               first_step_in  = 1'b0;
               score_sum_in   = sum_upd;
               kept_count_in  = count_upd;
            end
         end else begin
            best_score_in    = best_cur;
            best_index_in    = idx_cur;
            class_counter_in = class_counter_ff + 1'b1;
         end
      end
   end

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (cmd.accept && stat.seq_end) begin
         dvd_in = sum_mag;
         rem_in = '0;
         dsr_in = count_upd;
         neg_in = sum_upd[SUM_W-1];
         cnt_in = '0;
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[SUM_W-2:0], ge};
         rem_in = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      full_in  = full_ff && !rsp_chan.ready;
      kind_in  = kind_ff;
      index_in = index_ff;
      mean_in  = mean_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (emit_char) begin
         full_in  = 1'b1;
         kind_in  = KIND_CHAR;
         index_in = idx_cur;
         mean_in  = '0;
         count_in = '0;
         last_in  = 1'b0;
      end else if (cmd.load_summary) begin
         full_in  = 1'b1;
         kind_in  = KIND_SUMMARY;
         index_in = '0;
         mean_in  = (dsr_ff == '0) ? '0 : quot_signed[SCORE_W-1:0];
         count_in = dsr_ff;
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff    <= SCORE_MIN;
         best_index_ff    <= '0;
         class_counter_ff <= '0;
         prev_argmax_ff   <= '0;
         first_step_ff    <= 1'b1;
         score_sum_ff     <= '0;
         kept_count_ff    <= '0;
         cnt_ff           <= '0;
         full_ff          <= 1'b0;
      end else begin
         best_score_ff    <= best_score_in;
         best_index_ff    <= best_index_in;
         class_counter_ff <= class_counter_in;
         prev_argmax_ff   <= prev_argmax_in;
         first_step_ff    <= first_step_in;
         score_sum_ff     <= score_sum_in;
         kept_count_ff    <= kept_count_in;
         cnt_ff           <= cnt_in;
         full_ff          <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      neg_ff   <= neg_in;
      kind_ff  <= kind_in;
      index_ff <= index_in;
      mean_ff  <= mean_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   assign rsp_chan.valid       = full_ff;
   assign rsp_chan.result_kind = kind_ff;
   assign rsp_chan.char_index  = index_ff;
   assign rsp_chan.mean_score  = mean_ff;
   assign rsp_chan.char_count  = count_ff;
   assign rsp_chan.last_result = last_ff;

endmodule

// File: design/ctc_greedy_decoder_unit.sv
// Top level of the CTC greedy decoder: register port, controller, datapath and checks.
//
//   channel   | direction | transaction
//   req_chan  | in        | one class score with step and sequence marks
//   rsp_chan  | out       | decoded character or sequence summary
//   csr_*     | in/out    | APB-style access to dict_size
//
// A score that ends a sequence is followed by a divider run (one quotient bit per step)
// and a summary issue that waits for result room, before the next score is taken.
// Reset is synchronous; no clearing pass.
// Input stalls while the result register holds a transaction not yet taken.
module ctc_greedy_decoder_unit (
   input  logic                        clock,
   input  logic                        reset,
   cgd_req_if.sink                     req_chan,
   cgd_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cgd_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [cgd_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [cgd_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import cgd_pkg::*;

   dict_type     dict_size_ff;
   dict_type     dict_size_in;
   logic         csr_write;
   ctl_cmd_type  cmd;
   ctl_stat_type stat;
   logic         req_ready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign dict_size_in = (csr_write && (csr_paddr == ADDR_DICT_SIZE)) ?
                         csr_pwdata[DICT_W-1:0] : dict_size_ff;
   assign csr_prdata = (csr_paddr == ADDR_DICT_SIZE) ? DATA_W'(dict_size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dict_size_ff <= DICT_RESET;
      end else begin
         dict_size_ff <= dict_size_in;
      end
   end

   assign req_chan.ready = req_ready;

   cgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cgd_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .class_score     (req_chan.class_score),
      .end_of_step     (req_chan.end_of_step),
      .end_of_sequence (req_chan.end_of_sequence),
      .dict_size       (dict_size_ff),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_chan        (rsp_chan)
   );

   a_no_accept_in_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_chan.ready)
      else $error("input accepted while divider runs");

   a_seq_end_stalls: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && stat.seq_end) |=> (cmd.div_step && !req_chan.ready))
      else $error("sequence end did not start divider");

   a_summary_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_summary |-> stat.out_free)
      else $error("summary overwrote pending transaction");

   a_summary_is_last: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.load_summary) |-> (rsp_chan.valid && rsp_chan.last_result))
      else $error("summary transaction missing last mark");

endmodule
